FILE: design/vsp_pkg.sv
// shared types, constants and parse step functions of the version string parser
// used by vsp_parse and version_string_parser; no dependencies

package vsp_pkg;

    // field limits of the accepted version format
    localparam int VSP_MAJOR_DIGITS    = 4;
    localparam int VSP_MINOR_DIGITS    = 2;
    localparam int VSP_REVISION_DIGITS = 2;
    localparam int VSP_LEVEL_DIGITS    = 3;

    localparam int VSP_VERSION_W = 41;

    // decimal weights of the packed version number
    localparam logic [VSP_VERSION_W-1:0] VSP_MAJOR_SCALE = 41'd100000000;
    localparam logic [19:0]              VSP_MINOR_SCALE = 20'd1000000;
    localparam logic [13:0]              VSP_REV_SCALE   = 14'd10000;
    localparam logic [9:0]               VSP_STAGE_SCALE = 10'd1000;
    localparam logic [9:0]               VSP_LEVEL_MAX   = 10'd255;

    // stage codes
    localparam logic [3:0] VSP_ST_NONE  = 4'd0;
    localparam logic [3:0] VSP_ST_DEV   = 4'd1;
    localparam logic [3:0] VSP_ST_ALPHA = 4'd3;
    localparam logic [3:0] VSP_ST_BETA  = 4'd5;
    localparam logic [3:0] VSP_ST_CAND  = 4'd7;
    localparam logic [3:0] VSP_ST_REL   = 4'd9;

    // character codes
    localparam logic [7:0] VSP_CH_NUL   = 8'h00;
    localparam logic [7:0] VSP_CH_TAB   = 8'h09;
    localparam logic [7:0] VSP_CH_LF    = 8'h0A;
    localparam logic [7:0] VSP_CH_CR    = 8'h0D;
    localparam logic [7:0] VSP_CH_SPACE = 8'h20;
    localparam logic [7:0] VSP_CH_DOT   = 8'h2E;
    localparam logic [7:0] VSP_CH_ZERO  = 8'h30;
    localparam logic [7:0] VSP_CH_NINE  = 8'h39;
    localparam logic [7:0] VSP_CH_A     = 8'h61;
    localparam logic [7:0] VSP_CH_B     = 8'h62;
    localparam logic [7:0] VSP_CH_C     = 8'h63;
    localparam logic [7:0] VSP_CH_D     = 8'h64;
    localparam logic [7:0] VSP_CH_F     = 8'h66;

    typedef enum logic [3:0] {
        PH_MAJ_FIRST,
        PH_MAJ,
        PH_MAJ_FULL,
        PH_MIN,
        PH_MIN_FULL,
        PH_REV,
        PH_REV_FULL,
        PH_STAGE,
        PH_NEED_DIGIT,
        PH_AFTER_F,
        PH_LVL,
        PH_LVL_FULL
    } t_vsp_phase;

    typedef struct packed {
        t_vsp_phase  phase;
        logic [2:0]  cnt;
        logic [13:0] major;
        logic [6:0]  minor;
        logic [6:0]  rev;
        logic [3:0]  stage;
        logic [9:0]  level;
        logic        settled;
        logic        err;
    } t_vsp_state;

    typedef struct packed {
        t_vsp_state st;
        logic       cont;
    } t_vsp_step;

    // finished parse of one string, handed to the arithmetic stages
    typedef struct packed {
        logic        ok;
        logic [13:0] major;
        logic [6:0]  minor;
        logic [6:0]  rev;
        logic [3:0]  stage;
        logic [7:0]  level;
    } t_vsp_fin;

    localparam t_vsp_state VSP_STATE_RST = '{
        phase:   PH_MAJ_FIRST,
        cnt:     3'd0,
        major:   14'd0,
        minor:   7'd0,
        rev:     7'd0,
        stage:   VSP_ST_NONE,
        level:   10'd0,
        settled: 1'b0,
        err:     1'b0
    };

    // level range check, candidate needs a nonzero level
    function automatic t_vsp_state vsp_settle(input t_vsp_state s);
        t_vsp_state r;
        r = s;
        if (s.level > VSP_LEVEL_MAX || (s.stage == VSP_ST_CAND && s.level == 10'd0)) begin
            r.err = 1'b1;
        end else begin
            r.settled = 1'b1;
        end
        return r;
    endfunction

    function automatic t_vsp_state vsp_settle_release(input t_vsp_state s);
        t_vsp_state r;
        r = s;
        r.stage = VSP_ST_REL;
        r.level = 10'd0;
        return vsp_settle(r);
    endfunction

    // one pass of the phase machine; cont asks for the same character again
    function automatic t_vsp_step vsp_step(input t_vsp_state s, input logic [7:0] c);
        t_vsp_step  r;
        logic       term;
        logic       dig;
        logic       letter;
        logic       dot;
        logic [3:0] d;
        logic [2:0] cnt_inc;
        r.st   = s;
        r.cont = 1'b0;
        term   = (c == VSP_CH_SPACE) || (c == VSP_CH_TAB) || (c == VSP_CH_CR) ||
                 (c == VSP_CH_LF) || (c == VSP_CH_NUL);
        dig    = (c >= VSP_CH_ZERO) && (c <= VSP_CH_NINE);
        d      = dig ? c[3:0] : 4'd0;
        letter = (c == VSP_CH_D) || (c == VSP_CH_A) || (c == VSP_CH_B) || (c == VSP_CH_F);
        dot    = (c == VSP_CH_DOT);
        cnt_inc = s.cnt + 3'd1;
        case (s.phase)
            PH_MAJ_FIRST: begin
                if (!dig) begin
                    r.st.err = 1'b1;
                end else begin
                    r.st.major = {10'd0, d};
                    r.st.cnt   = 3'd1;
                    r.st.phase = (3'd1 >= 3'(VSP_MAJOR_DIGITS)) ? PH_MAJ_FULL : PH_MAJ;
                end
            end
            PH_MAJ: begin
                if (term) begin
                    r.st = vsp_settle_release(s);
                end else if (dig) begin
                    r.st.major = s.major * 14'd10 + {10'd0, d};
                    r.st.cnt   = cnt_inc;
                    if (cnt_inc >= 3'(VSP_MAJOR_DIGITS)) r.st.phase = PH_MAJ_FULL;
                end else if (letter) begin
                    r.st.phase = PH_STAGE;
                    r.cont     = 1'b1;
                end else if (dot) begin
                    r.st.phase = PH_MIN;
                    r.st.cnt   = 3'd0;
                end else begin
                    r.st.err = 1'b1;
                end
            end
            PH_MAJ_FULL: begin
                if (dig) begin
                    r.st.err = 1'b1;
                end else begin
                    r.st.phase = PH_MIN;
                    r.st.cnt   = 3'd0;
                    r.cont     = !dot;
                end
            end
            PH_MIN: begin
                if (term) begin
                    r.st = vsp_settle_release(s);
                end else if (dig) begin
                    r.st.minor = s.minor * 7'd10 + {3'd0, d};
                    r.st.cnt   = cnt_inc;
                    if (cnt_inc >= 3'(VSP_MINOR_DIGITS)) r.st.phase = PH_MIN_FULL;
                end else if (letter) begin
                    r.st.phase = PH_STAGE;
                    r.cont     = 1'b1;
                end else if (dot) begin
                    r.st.phase = PH_REV;
                    r.st.cnt   = 3'd0;
                end else begin
                    r.st.err = 1'b1;
                end
            end
            PH_MIN_FULL: begin
                if (dig) begin
                    r.st.err = 1'b1;
                end else begin
                    r.st.phase = PH_REV;
                    r.st.cnt   = 3'd0;
                    r.cont     = !dot;
                end
            end
            PH_REV: begin
                if (term) begin
                    r.st = vsp_settle_release(s);
                end else if (dig) begin
                    r.st.rev = s.rev * 7'd10 + {3'd0, d};
                    r.st.cnt = cnt_inc;
                    if (cnt_inc >= 3'(VSP_REVISION_DIGITS)) r.st.phase = PH_REV_FULL;
                end else if (letter) begin
                    r.st.phase = PH_STAGE;
                    r.cont     = 1'b1;
                end else begin
                    r.st.err = 1'b1;
                end
            end
            PH_REV_FULL: begin
                if (dig) begin
                    r.st.err = 1'b1;
                end else begin
                    r.st.phase = PH_STAGE;
                    r.cont     = !dot;
                end
            end
            PH_STAGE: begin
                if (term) begin
                    r.st = vsp_settle_release(s);
                end else if (c == VSP_CH_D) begin
                    r.st.stage = VSP_ST_DEV;
                    r.st.phase = PH_NEED_DIGIT;
                end else if (c == VSP_CH_A) begin
                    r.st.stage = VSP_ST_ALPHA;
                    r.st.phase = PH_NEED_DIGIT;
                end else if (c == VSP_CH_B) begin
                    r.st.stage = VSP_ST_BETA;
                    r.st.phase = PH_NEED_DIGIT;
                end else if (c == VSP_CH_F) begin
                    r.st.stage = VSP_ST_CAND;
                    r.st.phase = PH_AFTER_F;
                end else begin
                    r.st.err = 1'b1;
                end
            end
            PH_NEED_DIGIT, PH_AFTER_F: begin
                if (dig) begin
                    r.st.level = {6'd0, d};
                    r.st.cnt   = 3'd1;
                    r.st.phase = (3'd1 >= 3'(VSP_LEVEL_DIGITS)) ? PH_LVL_FULL : PH_LVL;
                end else if (s.phase == PH_AFTER_F && c == VSP_CH_C) begin
                    r.st.phase = PH_NEED_DIGIT;
                end else begin
                    r.st.err = 1'b1;
                end
            end
            PH_LVL: begin
                if (term) begin
                    r.st = vsp_settle(s);
                end else if (dig) begin
                    r.st.level = s.level * 10'd10 + {6'd0, d};
                    r.st.cnt   = cnt_inc;
                    if (cnt_inc >= 3'(VSP_LEVEL_DIGITS)) r.st.phase = PH_LVL_FULL;
                end else begin
                    r.st.err = 1'b1;
                end
            end
            PH_LVL_FULL: begin
                if (term) begin
                    r.st = vsp_settle(s);
                end else begin
                    r.st.err = 1'b1;
                end
            end
            default: begin
                r.st.err = 1'b1;
            end
        endcase
        return r;
    endfunction

    // a character revisits at most three phases (full field, next field, stage)
    function automatic t_vsp_state vsp_take(input t_vsp_state s, input logic [7:0] c);
        t_vsp_step p1;
        t_vsp_step p2;
        t_vsp_step p3;
        p1 = vsp_step(s, c);
        p2 = p1.cont ? vsp_step(p1.st, c) : p1;
        p3 = p2.cont ? vsp_step(p2.st, c) : p2;
        return (s.settled || s.err) ? s : p3.st;
    endfunction

endpackage

FILE: design/vsp_parse.sv
// character parser: phase machine state and the finished-parse register
// depends on vsp_pkg

module vsp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_char,
    input  logic                i_last,
    input  logic                i_fin_ready,
    input  logic                i_fin_pop,
    output logic                o_take,
    output logic                o_fin_valid,
    output vsp_pkg::t_vsp_fin   o_fin
);

    vsp_pkg::t_vsp_state r_state;
    vsp_pkg::t_vsp_state n_state;
    vsp_pkg::t_vsp_state n_end;
    logic                r_fin_valid;
    vsp_pkg::t_vsp_fin   r_fin;
    vsp_pkg::t_vsp_fin   n_fin;

    // a final character waits until the finished-parse register is free
    assign o_take = i_valid && (!i_last || i_fin_ready);

    always_comb begin
        n_state = vsp_pkg::vsp_take(r_state, i_char);
        // end of string acts as a terminator
        n_end   = vsp_pkg::vsp_take(n_state, vsp_pkg::VSP_CH_NUL);
        n_fin.ok = n_end.settled && !n_end.err;
        if (n_fin.ok) begin
            n_fin.major = n_end.major;
            n_fin.minor = n_end.minor;
            n_fin.rev   = n_end.rev;
            n_fin.stage = n_end.stage;
            n_fin.level = n_end.level[7:0];
        end else begin
            n_fin.major = '0;
            n_fin.minor = '0;
            n_fin.rev   = '0;
            n_fin.stage = vsp_pkg::VSP_ST_NONE;
            n_fin.level = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vsp_pkg::VSP_STATE_RST;
            r_fin_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_state <= i_last ? vsp_pkg::VSP_STATE_RST : n_state;
            end
            if (o_take && i_last) begin
                r_fin_valid <= 1'b1;
            end else if (i_fin_pop) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_last) begin
            r_fin <= n_fin;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

endmodule

FILE: design/version_string_parser.sv
// top level of the version string parser: input register, parser, scaling and sum stages
// depends on vsp_pkg and vsp_parse

// Takes a version string one byte per transaction and returns one result transaction
// for the byte marked last. The format is major (1-4 digits), optional dot, minor (up to
// 2 digits), optional dot, revision (up to 2 digits), then an optional stage letter
// d, a, b, f or fc with a 1-3 digit level of at most 255. Space, tab, CR, LF, NUL or the
// end of the string end parsing; later bytes are ignored until the last one. A legal
// string gives major*1e8 + minor*1e6 + revision*1e4 + stage*1000 + level together with
// the separate parts; anything else gives version -1 and zero parts. One byte is taken
// every clock with no gaps between strings while o_stall is low. The result passes through
// the input register, then the parse step into the finished-parse register, the decimal
// scaling multipliers, and the final sum into the output register. Each stage holds while
// the next one is full, so the input keeps flowing into free stages while a result waits
// for the output side.

module version_string_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic signed [40:0] o_version,
    output logic [13:0] o_major_part,
    output logic [6:0]  o_minor_part,
    output logic [6:0]  o_revision_part,
    output logic [3:0]  o_stage_code,
    output logic [7:0]  o_stage_level
);

    // stage ready chain, output side first
    logic out_ready;
    logic prod_ready;
    logic fin_ready;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       in_take;
    logic       in_accept;

    // parser outputs
    logic              fin_valid;
    vsp_pkg::t_vsp_fin fin;

    // scaled products
    logic                              r_prod_valid;
    logic                              r_prod_ok;
    logic [vsp_pkg::VSP_VERSION_W-1:0] r_prod_major;
    logic [26:0]                       r_prod_minor;
    logic [20:0]                       r_prod_rev;
    logic [13:0]                       r_prod_low;
    vsp_pkg::t_vsp_fin                 r_prod_fin;

    // output register
    logic        r_out_valid;
    logic        r_out_ok;
    logic [40:0] r_out_version;
    logic [40:0] n_out_version;
    vsp_pkg::t_vsp_fin r_out_fin;

    assign out_ready  = !r_out_valid || !i_stall;
    assign prod_ready = !r_prod_valid || out_ready;
    assign fin_ready  = !fin_valid || prod_ready;

    // input register frees up when the parser takes its byte
    assign o_stall   = r_in_valid && !in_take;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (in_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    vsp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .i_fin_ready (fin_ready),
        .i_fin_pop   (prod_ready),
        .o_take      (in_take),
        .o_fin_valid (fin_valid),
        .o_fin       (fin)
    );

    // decimal scaling, one constant multiplier each for major, minor, revision and stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (fin_valid && prod_ready) begin
            r_prod_valid <= 1'b1;
        end else if (out_ready) begin
            r_prod_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_valid && prod_ready) begin
            r_prod_ok    <= fin.ok;
            r_prod_fin   <= fin;
            r_prod_major <= {27'd0, fin.major} * vsp_pkg::VSP_MAJOR_SCALE;
            r_prod_minor <= {20'd0, fin.minor} * {7'd0, vsp_pkg::VSP_MINOR_SCALE};
            r_prod_rev   <= {14'd0, fin.rev} * {7'd0, vsp_pkg::VSP_REV_SCALE};
            r_prod_low   <= {10'd0, fin.stage} * {4'd0, vsp_pkg::VSP_STAGE_SCALE}
                            + {6'd0, fin.level};
        end
    end

    // final sum, all ones for an invalid string
    always_comb begin
        if (r_prod_ok) begin
            n_out_version = r_prod_major + {14'd0, r_prod_minor} + {20'd0, r_prod_rev}
                            + {27'd0, r_prod_low};
        end else begin
            n_out_version = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_prod_valid && out_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_prod_valid && out_ready) begin
            r_out_ok      <= r_prod_ok;
            r_out_version <= n_out_version;
            r_out_fin     <= r_prod_fin;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_valid_res     = r_out_ok;
    assign o_version       = $signed(r_out_version);
    assign o_major_part    = r_out_fin.major;
    assign o_minor_part    = r_out_fin.minor;
    assign o_revision_part = r_out_fin.rev;
    assign o_stage_code    = r_out_fin.stage;
    assign o_stage_level   = r_out_fin.level;

    // invalid result carries version -1, zero major part, no stage code and zero level
    a_invalid_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> ((&r_out_version) && o_major_part == 14'd0 &&
            o_stage_code == vsp_pkg::VSP_ST_NONE && o_stage_level == 8'd0))
        else $error("invalid result not in canonical form");

    // legal result always carries a real stage code
    a_stage_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |-> (o_stage_code == vsp_pkg::VSP_ST_DEV ||
            o_stage_code == vsp_pkg::VSP_ST_ALPHA || o_stage_code == vsp_pkg::VSP_ST_BETA ||
            o_stage_code == vsp_pkg::VSP_ST_CAND || o_stage_code == vsp_pkg::VSP_ST_REL))
        else $error("legal result with bad stage code");

    // release has no level, candidate never level zero
    a_level_rules: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |->
            ((o_stage_code != vsp_pkg::VSP_ST_REL || o_stage_level == 8'd0) &&
             (o_stage_code != vsp_pkg::VSP_ST_CAND || o_stage_level != 8'd0)))
        else $error("stage level rule broken");

    // a held product is not lost while the output register is blocked
    a_prod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prod_valid && !out_ready) |=> (r_prod_valid && $stable(r_prod_major)))
        else $error("scaling stage dropped a result");

endmodule
